/* hdl/prc_pkg.sv */
// Shared types, constants and sizes for the packet rule classifier.
`timescale 1ns / 1ps
package prc_pkg;

	// Table sizes
	localparam int RULE_ENTRIES      = 16;
	localparam int BLACKLIST_ENTRIES = 16;

	localparam int RULE_IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
	localparam int BL_IDX_W   = (BLACKLIST_ENTRIES > 1) ? $clog2(BLACKLIST_ENTRIES) : 1;
	localparam int RULE_CNT_W = $clog2(RULE_ENTRIES + 1);
	localparam int BL_CNT_W   = $clog2(BLACKLIST_ENTRIES + 1);
	localparam int SCAN_W     = (RULE_CNT_W > BL_CNT_W) ? RULE_CNT_W : BL_CNT_W;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	// Item kinds
	localparam logic KIND_RULE   = 1'b0;
	localparam logic KIND_PACKET = 1'b1;

	// Rule types
	localparam logic [2:0] RT_HIGH_RISK   = 3'd0;
	localparam logic [2:0] RT_BLOCK_ADDR  = 3'd1;
	localparam logic [2:0] RT_BLOCK_PROTO = 3'd2;
	localparam logic [2:0] RT_BLOCK_PORT  = 3'd3;
	localparam logic [2:0] RT_ALLOW_PORT  = 3'd4;
	localparam logic [2:0] RT_ALLOW_PROTO = 3'd5;

	// Reason codes
	localparam logic [3:0] RC_NONE         = 4'd0;
	localparam logic [3:0] RC_NO_MATCH     = 4'd1;
	localparam logic [3:0] RC_RISK         = 4'd2;
	localparam logic [3:0] RC_ADDR         = 4'd3;
	localparam logic [3:0] RC_PROTO        = 4'd4;
	localparam logic [3:0] RC_PORT_BLOCKED = 4'd5;
	localparam logic [3:0] RC_PORT_OK      = 4'd6;
	localparam logic [3:0] RC_PROTO_OK     = 4'd7;
	localparam logic [3:0] RC_LISTED       = 4'd8;
	localparam logic [3:0] RC_AUTO_LISTED  = 4'd9;

	// Risk thresholds
	localparam logic [3:0] RISK_HIGH_MAX  = 4'd7;
	localparam logic [3:0] RISK_THREAT_LO = 4'd8;
	localparam logic [3:0] RISK_THREAT_HI = 4'd9;
	localparam logic [3:0] RISK_CRITICAL  = 4'd10;

	// Classified item as handed from front to back
	typedef struct packed {
		logic        kind;
		logic [2:0]  rule_type;
		logic [31:0] rule_operand;
		logic [31:0] source_address;
		logic [1:0]  protocol_code;
		logic [15:0] dest_port;
		logic        risk_high;   // risk above 7
		logic        threat;      // risk 8 or 9
		logic        critical;    // risk 10 and above
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} cmdq_status_t;

	typedef struct packed {
		logic       verdict;
		logic [3:0] reason_code;
		logic       threat_flag;
		logic       rule_accepted;
		logic       blacklist_overflow;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BL_SCAN,
		ST_RULE_SCAN,
		ST_FINISH
	} state_t;

endpackage

/* hdl/prc_front.sv */
// Front end: accepts items, classifies packet risk and hands them to the command queue.
`timescale 1ns / 1ps
module prc_front import prc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic         kind,
	input  logic [2:0]   rule_type,
	input  logic [31:0]  rule_operand,
	input  logic [31:0]  source_address,
	input  logic [1:0]   protocol_code,
	input  logic [15:0]  dest_port,
	input  logic [3:0]   risk_level,
	input  cmdq_status_t q_status,
	output logic         q_push,
	output cmd_t         q_data
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic accept;

	assign full   = valid_s1 && q_status.full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !q_status.full;
	assign q_data = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_status.full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind           <= kind;
			cmd_s1.rule_type      <= rule_type;
			cmd_s1.rule_operand   <= rule_operand;
			cmd_s1.source_address <= source_address;
			cmd_s1.protocol_code  <= protocol_code;
			cmd_s1.dest_port      <= dest_port;
			cmd_s1.risk_high      <= risk_level > RISK_HIGH_MAX;
			cmd_s1.threat         <= (risk_level == RISK_THREAT_LO) ||
			                         (risk_level == RISK_THREAT_HI);
			cmd_s1.critical       <= risk_level >= RISK_CRITICAL;
		end
	end

endmodule

/* hdl/prc_cmd_fifo.sv */
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module prc_cmd_fifo import prc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  cmd_t         wr_data,
	input  logic         rd_en,
	output cmd_t         rd_data,
	output cmdq_status_t status
);

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	function automatic logic [CMDQ_PTR_W-1:0] ptr_inc(input logic [CMDQ_PTR_W-1:0] p);
		ptr_inc = (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* hdl/prc_back.sv */
// Back end: rule table and blacklist memories, scan sequencer and result register.
`timescale 1ns / 1ps
module prc_back import prc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmdq_status_t q_status,
	input  cmd_t         q_data,
	output logic         q_pop,
	input  logic         pop,
	output logic         empty,
	output result_t      result
);

	state_t state_q, state_d;

	cmd_t                  cur_q;
	logic [RULE_CNT_W-1:0] rule_cnt_q;
	logic [BL_CNT_W-1:0]   bl_cnt_q;
	logic [SCAN_W-1:0]     idx_q;
	logic                  cmp_vld_q;
	logic                  listed_q;
	logic                  verdict_q;
	logic [3:0]            reason_q;
	logic                  accepted_q;
	logic                  res_valid_q;
	result_t               res_q;

	// memories
	logic [2:0]  rule_type_mem_q [RULE_ENTRIES];
	logic [31:0] rule_op_mem_q   [RULE_ENTRIES];
	logic [31:0] bl_mem_q        [BLACKLIST_ENTRIES];
	logic [2:0]  rule_type_rd_q;
	logic [31:0] rule_op_rd_q;
	logic [31:0] bl_rd_q;

	logic    fetch;
	logic    bl_issue;
	logic    rule_issue;
	logic    scan_done;
	logic    res_load;
	logic    rule_we;
	logic    bl_insert;
	logic    rule_full;
	logic    bl_full;
	logic    rule_hit;
	logic    rule_block;
	logic [3:0] rule_reason;
	result_t fin_res;

	assign rule_full = (rule_cnt_q == RULE_CNT_W'(RULE_ENTRIES));
	assign bl_full   = (bl_cnt_q == BL_CNT_W'(BLACKLIST_ENTRIES));
	assign q_pop     = fetch;
	assign empty     = !res_valid_q;
	assign result    = res_q;

	// sequencer
	always_comb begin
		state_d    = state_q;
		fetch      = 1'b0;
		bl_issue   = 1'b0;
		rule_issue = 1'b0;
		scan_done  = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					fetch   = 1'b1;
					state_d = (q_data.kind == KIND_PACKET) ? ST_BL_SCAN : ST_FINISH;
				end
			end
			ST_BL_SCAN: begin
				bl_issue = idx_q < SCAN_W'(bl_cnt_q);
				if (!bl_issue && !cmp_vld_q) begin
					scan_done = 1'b1;
					state_d   = (listed_q || rule_cnt_q == '0) ? ST_FINISH : ST_RULE_SCAN;
				end
			end
			ST_RULE_SCAN: begin
				rule_issue = idx_q < SCAN_W'(rule_cnt_q);
				if (!rule_issue && !cmp_vld_q) begin
					scan_done = 1'b1;
					state_d   = ST_FINISH;
				end
			end
			ST_FINISH: begin
				res_load = !res_valid_q || pop;
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// rule decoder on the registered read data
	always_comb begin
		rule_hit    = 1'b0;
		rule_block  = 1'b0;
		rule_reason = RC_NONE;
		unique case (rule_type_rd_q)
			RT_HIGH_RISK: begin
				rule_hit    = cur_q.risk_high;
				rule_block  = 1'b1;
				rule_reason = RC_RISK;
			end
			RT_BLOCK_ADDR: begin
				rule_hit    = rule_op_rd_q == cur_q.source_address;
				rule_block  = 1'b1;
				rule_reason = RC_ADDR;
			end
			RT_BLOCK_PROTO: begin
				rule_hit    = rule_op_rd_q == {30'd0, cur_q.protocol_code};
				rule_block  = 1'b1;
				rule_reason = RC_PROTO;
			end
			RT_BLOCK_PORT: begin
				rule_hit    = rule_op_rd_q == {16'd0, cur_q.dest_port};
				rule_block  = 1'b1;
				rule_reason = RC_PORT_BLOCKED;
			end
			RT_ALLOW_PORT: begin
				rule_hit    = rule_op_rd_q == {16'd0, cur_q.dest_port};
				rule_reason = RC_PORT_OK;
			end
			RT_ALLOW_PROTO: begin
				rule_hit    = rule_op_rd_q == {30'd0, cur_q.protocol_code};
				rule_reason = RC_PROTO_OK;
			end
			default: begin
				rule_hit = 1'b0;    // stored but inert
			end
		endcase
	end

	// final result; critical risk overrides the lookup and lists the source if room
	always_comb begin
		fin_res   = '0;
		bl_insert = 1'b0;
		if (cur_q.kind == KIND_RULE) begin
			fin_res.rule_accepted = accepted_q;
		end else begin
			fin_res.verdict     = listed_q ? 1'b1 : verdict_q;
			fin_res.reason_code = listed_q ? RC_LISTED : reason_q;
			fin_res.threat_flag = cur_q.threat;
			if (cur_q.critical) begin
				fin_res.verdict            = 1'b1;
				fin_res.reason_code        = RC_AUTO_LISTED;
				fin_res.blacklist_overflow = !listed_q && bl_full;
				bl_insert                  = res_load && !listed_q && !bl_full;
			end
		end
	end

	assign rule_we = fetch && (q_data.kind == KIND_RULE) && !rule_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_cnt_q  <= '0;
			bl_cnt_q    <= '0;
			idx_q       <= '0;
			cmp_vld_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			cmp_vld_q <= bl_issue || rule_issue;
			if (fetch || scan_done) begin
				idx_q <= '0;
			end else if (bl_issue || rule_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rule_we) begin
				rule_cnt_q <= rule_cnt_q + 1'b1;
			end
			if (bl_insert) begin
				bl_cnt_q <= bl_cnt_q + 1'b1;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch) begin
			cur_q      <= q_data;
			accepted_q <= rule_we;
			listed_q   <= 1'b0;
			verdict_q  <= 1'b0;
			reason_q   <= (rule_cnt_q == '0) ? RC_NONE : RC_NO_MATCH;
		end else begin
			if (state_q == ST_BL_SCAN && cmp_vld_q && bl_rd_q == cur_q.source_address) begin
				listed_q <= 1'b1;
			end
			if (state_q == ST_RULE_SCAN && cmp_vld_q && rule_hit) begin
				verdict_q <= rule_block;
				reason_q  <= rule_reason;
			end
		end
		if (res_load) begin
			res_q <= fin_res;
		end
	end

	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_type_mem_q[rule_cnt_q[RULE_IDX_W-1:0]] <= q_data.rule_type;
			rule_op_mem_q[rule_cnt_q[RULE_IDX_W-1:0]]   <= q_data.rule_operand;
		end
		rule_type_rd_q <= rule_type_mem_q[idx_q[RULE_IDX_W-1:0]];
		rule_op_rd_q   <= rule_op_mem_q[idx_q[RULE_IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (bl_insert) begin
			bl_mem_q[bl_cnt_q[BL_IDX_W-1:0]] <= cur_q.source_address;
		end
		bl_rd_q <= bl_mem_q[idx_q[BL_IDX_W-1:0]];
	end

	// checks
	a_rule_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rule_cnt_q <= RULE_CNT_W'(RULE_ENTRIES))
		else $error("rule count beyond table size");

	a_bl_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bl_cnt_q <= BL_CNT_W'(BLACKLIST_ENTRIES))
		else $error("blacklist count beyond store size");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || pop))
		else $error("waiting result overwritten");

	a_rule_item_skips_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(fetch && q_data.kind == KIND_RULE) |=> (state_q == ST_FINISH))
		else $error("rule item entered a scan");

	a_insert_only_critical: assert property (@(posedge clk) disable iff (!arst_n)
		bl_insert |-> (cur_q.kind == KIND_PACKET && cur_q.critical && !listed_q))
		else $error("blacklist insert without critical unlisted packet");

endmodule

/* hdl/packet_rule_classifier.sv */
// Top level of the packet rule classifier: front end, command queue and back end.
`timescale 1ns / 1ps
// Packet rule classifier. Items come in through a queue-style port (push/full)
// and results leave through one (empty/pop), one result per item, in order.
// A rule item (kind 0) appends a rule to a 16-entry ordered table and reports
// rule_accepted; a packet item (kind 1) is checked against a 16-entry address
// blacklist and then against every rule, last match winning, default allow.
// Risk 8..9 raises threat_flag; risk 10 and up forces a block with reason
// auto-listed and adds the source address to the blacklist (overflow flagged
// when it is full). A rule item skips both scans. The back end reads one
// memory entry per cycle through a single registered read port per store,
// and the rule scan is skipped for a listed address or an empty table. An
// accepted item passes through the front register and the command queue
// before the back end fetches it.
// The front end and a two-entry command queue keep taking items while the
// back end scans and while a finished result waits to be popped.
module packet_rule_classifier import prc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input queue side
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [2:0]  rule_type,
	input  logic [31:0] rule_operand,
	input  logic [31:0] source_address,
	input  logic [1:0]  protocol_code,
	input  logic [15:0] dest_port,
	input  logic [3:0]  risk_level,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output logic        verdict,
	output logic [3:0]  reason_code,
	output logic        threat_flag,
	output logic        rule_accepted,
	output logic        blacklist_overflow
);

	cmdq_status_t q_status;
	logic         q_push;
	cmd_t         q_wr_data;
	logic         q_pop;
	cmd_t         q_rd_data;
	result_t      result;

	// front end: one item register plus risk classification
	prc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.rule_type      (rule_type),
		.rule_operand   (rule_operand),
		.source_address (source_address),
		.protocol_code  (protocol_code),
		.dest_port      (dest_port),
		.risk_level     (risk_level),
		.q_status       (q_status),
		.q_push         (q_push),
		.q_data         (q_wr_data)
	);

	// decoupling queue between front and back
	prc_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.rd_en   (q_pop),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	// back end: table updates, blacklist and rule scans, result register
	prc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_data   (q_rd_data),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	assign verdict            = result.verdict;
	assign reason_code        = result.reason_code;
	assign threat_flag        = result.threat_flag;
	assign rule_accepted      = result.rule_accepted;
	assign blacklist_overflow = result.blacklist_overflow;

endmodule
